// File: rtl/core/spa_pkg.sv
// Shared constants, codes and types of the stepped page allocator.
package spa_pkg;

    localparam int PAGE_BITS_DEF  = 40;
    localparam int POOL_DEPTH_DEF = 16;

    localparam int CAP_BITS  = 17;
    localparam int STEP_BITS = 9;
    localparam int IDX_BITS  = 8;
    localparam int RUN_BITS  = 25;
    localparam int PROD_W    = 26;
    localparam int OFF_BITS  = 26;

    localparam logic [CAP_BITS-1:0]  CAP_RESET  = CAP_BITS'(16);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(4);
    localparam logic [CAP_BITS-1:0]  CAP_MAX    = CAP_BITS'(65536);
    localparam logic [STEP_BITS-1:0] STEP_MAX   = STEP_BITS'(256);
    localparam logic [RUN_BITS:0]    RUN_MAX    = {1'b0, {RUN_BITS{1'b1}}};

    typedef enum logic [1:0] {
        OP_APPEND_ONE = 2'd0,
        OP_APPEND_RUN = 2'd1,
        OP_RESERVE    = 2'd2,
        OP_REPOSITION = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_EXCEEDS   = 3'd2,
        ST_NO_STEP   = 3'd3,
        ST_POOL_FULL = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_BLOCK_CAPACITY = 1'b0,
        CFG_STEP_SIZE      = 1'b1
    } cfg_idx_t;

endpackage

// File: rtl/core/spa_div.sv
// Restoring divider, one quotient bit per cycle, 17-bit divisor.
module spa_div
    import spa_pkg::*;
#(
    parameter int DW = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DW-1:0]       dividend,
    input  logic [CAP_BITS-1:0] divisor,
    output logic                done,
    output logic [DW-1:0]       quotient,
    output logic [CAP_BITS-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CAP_BITS-1:0] rem_reg;
    logic [DW-1:0]       quo_reg;
    logic [CAP_BITS-1:0] dsr_reg;
    logic [CAP_BITS:0]   trial;
    logic [CAP_BITS:0]   diff;
    logic                ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[CAP_BITS-1:0] : trial[CAP_BITS-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/stepped_page_allocator_core.sv
// Stepped page allocator: top level with sequencer, block state and run pool memory.
//
// One word is handled at a time. A hit on the front pool run goes straight to the output
// state; other appends and reserves may open a new block, read the step room and act, going
// through the divider (DW = max(PAGE_BITS, 26)) when the position moves, and through S_ADD
// when a leftover run is pushed to the pool. A reposition past the end page takes two passes
// through the bit-serial divider. S_OUT holds while the previous result still waits in the
// output register. The run pool sits in a registered-read memory; a new word is taken while
// a finished result still waits at the output.
module stepped_page_allocator_core
    import spa_pkg::*;
#(
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [CAP_BITS-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [RUN_BITS-1:0]  run_pages,
    input  logic [PAGE_BITS-1:0] target_page,
    input  logic [PAGE_BITS-1:0] file_tail_page,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PAGE_BITS-1:0] page_number,
    output logic [2:0]           status,
    output logic [PAGE_BITS-1:0] end_page
);

    localparam int PB = PAGE_BITS;
    localparam int DW = (PAGE_BITS > OFF_BITS) ? PAGE_BITS : OFF_BITS;
    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int UW = $clog2(POOL_DEPTH + 1);
    localparam int SW = UW + 1;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_POOL    = 13'b0000000000010,
        S_OPEN    = 13'b0000000000100,
        S_REM     = 13'b0000000001000,
        S_ACT     = 13'b0000000010000,
        S_ADD     = 13'b0000000100000,
        S_NEWSTEP = 13'b0000001000000,
        S_MOVE    = 13'b0000010000000,
        S_MCHK    = 13'b0000100000000,
        S_DIVM    = 13'b0001000000000,
        S_DIVR1   = 13'b0010000000000,
        S_DIVR2   = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_BITS-1:0]  cap_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [PROD_W-1:0]    sc_reg;

    logic [PB-1:0]        bfp_reg, bfp_next;
    logic [CAP_BITS-1:0]  fill_reg, fill_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic                 known_reg, known_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [UW-1:0]        used_reg, used_next;

    op_t                  op_reg, op_next;
    logic [RUN_BITS-1:0]  cnt_reg;
    logic [PB-1:0]        target_reg;
    logic [PB-1:0]        tail_reg;
    logic [PB-1:0]        page_reg, page_next;
    status_t              status_reg, status_next;
    logic [PB-1:0]        pend_reg, pend_next;
    logic [PROD_W-1:0]    rem_reg;
    logic [PB-1:0]        cur_reg;
    logic [OFF_BITS-1:0]  off_reg;

    logic                 out_valid_reg;
    logic [PB-1:0]        out_page_reg;
    logic [2:0]           out_status_reg;
    logic [PB-1:0]        out_end_reg;

    logic [PB-1:0]        run_start_mem [POOL_DEPTH];
    logic [RUN_BITS-1:0]  run_len_mem   [POOL_DEPTH];
    logic [PB-1:0]        rd_start_reg;
    logic [RUN_BITS-1:0]  rd_len_reg;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [PB-1:0]        wr_start;
    logic [RUN_BITS-1:0]  wr_len;

    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [CAP_BITS-1:0]  div_divisor;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [CAP_BITS-1:0]  div_rem;

    logic [CAP_BITS-1:0]  c_eff;
    logic [STEP_BITS-1:0] s_eff;
    logic                 idx_lt_s;
    logic [STEP_BITS-1:0] span;
    logic [PROD_W-1:0]    span_prod;
    logic [DW-1:0]        step_end_w;
    logic [PB-1:0]        step_end;
    logic [PB-1:0]        new_first;
    logic [PB-1:0]        cur_page;
    logic [STEP_BITS-1:0] rem_mult;
    logic [PROD_W-1:0]    rem_prod;
    logic [CAP_BITS-1:0]  rem_tail;
    logic [PROD_W-1:0]    rem_val;
    logic [PROD_W-1:0]    idx_prod;
    logic [OFF_BITS-1:0]  off_val;
    logic [AW-1:0]        head_inc;
    logic [SW-1:0]        tail_sum;
    logic [AW-1:0]        tail_addr;
    logic [AW-1:0]        last_addr;
    logic [RUN_BITS-1:0]  need;
    logic [DW-1:0]        take_w;
    logic [DW-1:0]        merge_w;
    logic [RUN_BITS:0]    merge_len;
    logic                 merge_ok;
    logic [STEP_BITS-1:0] nb_raw;
    logic [STEP_BITS-1:0] nb_fix;
    logic [CAP_BITS-1:0]  nf_fix;
    logic [STEP_BITS-1:0] delta;
    logic [PROD_W-1:0]    delta_prod;
    logic [DW-1:0]        move_w;
    logic [PB-1:0]        bid_raw;
    logic                 f_zero;
    logic [PB-1:0]        bid_fix;
    logic [CAP_BITS-1:0]  f_fix;
    logic [PB-1:0]        repo_first;
    op_t                  op_in;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        if (cap_reg == '0)
            c_eff = CAP_BITS'(1);
        else if (cap_reg > CAP_MAX)
            c_eff = CAP_MAX;
        else
            c_eff = cap_reg;
        if (step_reg == '0)
            s_eff = STEP_BITS'(1);
        else if (step_reg > STEP_MAX)
            s_eff = STEP_MAX;
        else
            s_eff = step_reg;
    end

    assign idx_lt_s   = {1'b0, idx_reg} < s_eff;
    assign span       = (known_reg && idx_lt_s) ? (s_eff - {1'b0, idx_reg}) : STEP_BITS'(1);
    assign span_prod  = span * c_eff;
    assign step_end_w = DW'(bfp_reg) + DW'(span_prod);
    assign step_end   = step_end_w[PB-1:0];
    assign new_first  = (step_end > tail_reg) ? step_end : tail_reg;
    assign cur_page   = bfp_reg + PB'(fill_reg);

    assign rem_mult = s_eff - {1'b0, idx_reg} - STEP_BITS'(1);
    assign rem_prod = rem_mult * c_eff;
    assign rem_tail = (fill_reg < c_eff) ? (c_eff - fill_reg) : '0;
    assign rem_val  = (known_reg && idx_lt_s) ? (rem_prod + PROD_W'(rem_tail)) : '0;
    assign idx_prod = idx_reg * c_eff;
    assign off_val  = OFF_BITS'(idx_prod) + OFF_BITS'(fill_reg) + OFF_BITS'(cnt_reg);

    assign head_inc  = (head_reg == AW'(POOL_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_sum  = SW'(head_reg) + SW'(used_reg);
    assign tail_addr = (tail_sum >= SW'(POOL_DEPTH)) ? AW'(tail_sum - SW'(POOL_DEPTH))
                                                     : AW'(tail_sum);
    assign last_addr = (tail_addr == '0) ? AW'(POOL_DEPTH - 1) : tail_addr - AW'(1);

    assign need      = (op_reg == OP_APPEND_ONE) ? RUN_BITS'(1) : cnt_reg;
    assign take_w    = DW'(rd_start_reg) + DW'(need);
    assign merge_w   = DW'(rd_start_reg) + DW'(rd_len_reg);
    assign merge_len = {1'b0, rd_len_reg} + {1'b0, rem_reg[RUN_BITS-1:0]};
    assign merge_ok  = (used_reg != '0) && (merge_w[PB-1:0] == cur_reg) && (merge_len <= RUN_MAX);

    assign nb_raw     = div_quo[STEP_BITS-1:0];
    assign nb_fix     = (nb_raw == s_eff) ? (s_eff - STEP_BITS'(1)) : nb_raw;
    assign nf_fix     = (nb_raw == s_eff) ? c_eff : div_rem;
    assign delta      = nb_fix - {1'b0, idx_reg};
    assign delta_prod = delta[IDX_BITS-1:0] * c_eff;
    assign move_w     = DW'(bfp_reg) + DW'(delta_prod);

    assign bid_raw    = div_quo[PB-1:0];
    assign f_zero     = (div_rem == '0);
    assign bid_fix    = f_zero ? (bid_raw - PB'(1)) : bid_raw;
    assign f_fix      = f_zero ? c_eff : div_rem;
    assign repo_first = target_reg - PB'(f_fix);

    assign op_in = ((operation == OP_APPEND_RUN) && (run_pages == RUN_BITS'(1)))
                   ? OP_APPEND_ONE : op_t'(operation);

    assign rd_addr = (state_reg == S_ACT) ? last_addr : head_reg;

    always_comb
    begin
        state_next   = state_reg;
        bfp_next     = bfp_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        known_next   = known_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        op_next      = op_reg;
        page_next    = page_reg;
        status_next  = status_reg;
        pend_next    = pend_reg;
        mem_we       = 1'b0;
        wr_addr      = head_reg;
        wr_start     = '0;
        wr_len       = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = c_eff;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_in;
                    page_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_POOL;
                end
            end
            S_POOL:
            begin
                unique case (op_reg)
                    OP_APPEND_ONE, OP_APPEND_RUN:
                    begin
                        if (op_reg == OP_APPEND_RUN && cnt_reg == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_OUT;
                        end
                        else if (used_reg != '0 && rd_len_reg >= need)
                        begin
                            page_next = rd_start_reg;
                            mem_we    = 1'b1;
                            wr_addr   = head_reg;
                            wr_start  = take_w[PB-1:0];
                            wr_len    = rd_len_reg - need;
                            if (rd_len_reg == need)
                            begin
                                head_next = head_inc;
                                used_next = used_reg - UW'(1);
                            end
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_OPEN;
                        end
                    end
                    OP_RESERVE:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_OPEN;
                        end
                    end
                    OP_REPOSITION:
                    begin
                        if (target_reg > cur_page)
                        begin
                            div_start    = 1'b1;
                            div_dividend = DW'(target_reg);
                            state_next   = S_DIVR1;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_OPEN:
            begin
                if (fill_reg >= c_eff)
                begin
                    fill_next = '0;
                    if (known_reg && (({1'b0, idx_reg} + STEP_BITS'(1)) < s_eff))
                    begin
                        bfp_next = bfp_reg + PB'(c_eff);
                        idx_next = idx_reg + IDX_BITS'(1);
                    end
                    else
                    begin
                        bfp_next   = new_first;
                        idx_next   = '0;
                        known_next = 1'b1;
                    end
                end
                state_next = S_REM;
            end
            S_REM:
            begin
                state_next = S_ACT;
            end
            S_ACT:
            begin
                priority if (op_reg == OP_APPEND_ONE)
                begin
                    page_next  = cur_reg;
                    fill_next  = fill_reg + CAP_BITS'(1);
                    state_next = S_OUT;
                end
                else if (op_reg == OP_APPEND_RUN)
                begin
                    if (!known_reg)
                    begin
                        status_next = ST_NO_STEP;
                        state_next  = S_OUT;
                    end
                    else if (PROD_W'(cnt_reg) > rem_reg)
                    begin
                        status_next = ST_EXCEEDS;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        pend_next  = cur_reg;
                        state_next = S_MOVE;
                    end
                end
                else if (known_reg)
                begin
                    if (PROD_W'(cnt_reg) > sc_reg)
                    begin
                        status_next = ST_EXCEEDS;
                        state_next  = S_OUT;
                    end
                    else if (rem_reg < PROD_W'(cnt_reg))
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        pend_next  = cur_reg;
                        state_next = S_MOVE;
                    end
                end
                else if (fill_reg > c_eff || cnt_reg > RUN_BITS'(c_eff - fill_reg))
                begin
                    status_next = ST_NO_STEP;
                    state_next  = S_OUT;
                end
                else
                begin
                    page_next  = cur_reg;
                    fill_next  = fill_reg + cnt_reg[CAP_BITS-1:0];
                    state_next = S_OUT;
                end
            end
            S_ADD:
            begin
                priority if (rem_reg == '0)
                begin
                    state_next = S_NEWSTEP;
                end
                else if (merge_ok)
                begin
                    mem_we     = 1'b1;
                    wr_addr    = last_addr;
                    wr_start   = rd_start_reg;
                    wr_len     = merge_len[RUN_BITS-1:0];
                    state_next = S_NEWSTEP;
                end
                else if (used_reg >= UW'(POOL_DEPTH))
                begin
                    status_next = ST_POOL_FULL;
                    state_next  = S_OUT;
                end
                else
                begin
                    mem_we     = 1'b1;
                    wr_addr    = tail_addr;
                    wr_start   = cur_reg;
                    wr_len     = rem_reg[RUN_BITS-1:0];
                    used_next  = used_reg + UW'(1);
                    state_next = S_NEWSTEP;
                end
            end
            S_NEWSTEP:
            begin
                bfp_next   = new_first;
                fill_next  = '0;
                idx_next   = '0;
                known_next = 1'b1;
                pend_next  = new_first;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                state_next = S_MCHK;
            end
            S_MCHK:
            begin
                if (PROD_W'(off_reg) > sc_reg)
                begin
                    status_next = ST_EXCEEDS;
                    state_next  = S_OUT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(off_reg);
                    state_next   = S_DIVM;
                end
            end
            S_DIVM:
            begin
                if (div_done)
                begin
                    bfp_next   = move_w[PB-1:0];
                    idx_next   = nb_fix[IDX_BITS-1:0];
                    fill_next  = nf_fix;
                    page_next  = pend_reg;
                    state_next = S_OUT;
                end
            end
            S_DIVR1:
            begin
                if (div_done)
                begin
                    bfp_next     = repo_first;
                    fill_next    = f_fix;
                    div_start    = 1'b1;
                    div_dividend = DW'(bid_fix);
                    div_divisor  = CAP_BITS'(s_eff);
                    state_next   = S_DIVR2;
                end
            end
            S_DIVR2:
            begin
                div_divisor = CAP_BITS'(s_eff);
                if (div_done)
                begin
                    idx_next   = div_rem[IDX_BITS-1:0];
                    known_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            step_reg      <= STEP_RESET;
            bfp_reg       <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            known_reg     <= 1'b1;
            head_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bfp_reg   <= bfp_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            known_reg <= known_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_BLOCK_CAPACITY: cap_reg  <= cfg_data;
                    CFG_STEP_SIZE:      step_reg <= cfg_data[STEP_BITS-1:0];
                    default:            cap_reg  <= cap_reg;
                endcase
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sc_reg     <= s_eff * c_eff;
        op_reg     <= op_next;
        page_reg   <= page_next;
        status_reg <= status_next;
        pend_reg   <= pend_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            cnt_reg    <= run_pages;
            target_reg <= target_page;
            tail_reg   <= file_tail_page;
        end
        if (state_reg == S_REM)
        begin
            rem_reg <= rem_val;
            cur_reg <= cur_page;
        end
        if (state_reg == S_MOVE)
            off_reg <= off_val;
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_page_reg   <= page_reg;
            out_status_reg <= status_reg;
            out_end_reg    <= cur_page;
        end
    end

    // pool reads never follow a write of the same word, so no forwarding path
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            run_start_mem[wr_addr] <= wr_start;
            run_len_mem[wr_addr]   <= wr_len;
        end
        rd_start_reg <= run_start_mem[rd_addr];
        rd_len_reg   <= run_len_mem[rd_addr];
    end

    spa_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_valid   = out_valid_reg;
    assign page_number = out_page_reg;
    assign status      = out_status_reg;
    assign end_page    = out_end_reg;

endmodule

// File: rtl/core/spa_checker.sv
// Port-level checks for the stepped page allocator, bound to the top level.
module spa_checker
    import spa_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [0:0]           cfg_index,
    input logic [CAP_BITS-1:0]  cfg_data,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [1:0]           operation,
    input logic [RUN_BITS-1:0]  run_pages,
    input logic [PAGE_BITS-1:0] target_page,
    input logic [PAGE_BITS-1:0] file_tail_page,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [PAGE_BITS-1:0] page_number,
    input logic [2:0]           status,
    input logic [PAGE_BITS-1:0] end_page
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(page_number) && $stable(status)
            && $stable(end_page))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_POOL_FULL))
        else $error("status code out of range");

    a_error_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (page_number == '0))
        else $error("page granted with error status");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

endmodule

bind stepped_page_allocator_core spa_checker #(.PAGE_BITS(PAGE_BITS)) u_spa_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench of the stepped page allocator core with a built-in predictor.
module testbench;
    import spa_pkg::*;

    localparam int PB = 40;
    localparam int PD = 16;
    localparam logic [PB-1:0] PMASK = {PB{1'b1}};

    typedef struct packed {
        logic [PB-1:0] page;
        logic [2:0]    st;
        logic [PB-1:0] endp;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [CAP_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic [RUN_BITS-1:0] run_pages = '0;
    logic [PB-1:0] target_page = '0;
    logic [PB-1:0] file_tail_page = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [PB-1:0] page_number;
    logic [2:0] status;
    logic [PB-1:0] end_page;

    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;
    int errors = 0;
    grant_t grants_due[$];

    // predictor state
    logic [63:0] m_cap, m_step;
    logic [63:0] m_first, m_fill, m_index;
    logic        m_known;
    logic [63:0] m_rstart [PD];
    logic [63:0] m_rlen [PD];
    int m_head, m_used;

    stepped_page_allocator_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #400000000;
        $display("stepped_page_allocator_core: mismatch");
        $finish;
    end

    function automatic logic [63:0] cap_now();
        if (m_cap == 0) return 1;
        return m_cap > 65536 ? 65536 : m_cap;
    endfunction

    function automatic logic [63:0] step_now();
        if (m_step == 0) return 1;
        return m_step > 256 ? 256 : m_step;
    endfunction

    function automatic logic [63:0] step_limit();
        logic [63:0] c, s;
        c = cap_now();
        s = step_now();
        if (m_known && m_index < s) return (m_first + (s - m_index) * c) & PMASK;
        return (m_first + c) & PMASK;
    endfunction

    function automatic void open_step(logic [63:0] tail);
        logic [63:0] e;
        e = step_limit();
        m_first = e > tail ? e : tail;
        m_fill = 0;
        m_index = 0;
        m_known = 1'b1;
    endfunction

    function automatic void open_block(logic [63:0] tail);
        if (m_known && m_index + 1 < step_now())
        begin
            m_first = (m_first + cap_now()) & PMASK;
            m_fill = 0;
            m_index++;
        end
        else
            open_step(tail);
    endfunction

    function automatic logic [63:0] step_room();
        logic [63:0] c, s;
        c = cap_now();
        s = step_now();
        if (!m_known || m_index >= s) return 0;
        return (s - m_index - 1) * c + (m_fill < c ? c - m_fill : 0);
    endfunction

    function automatic bit advance(logic [63:0] n);
        logic [63:0] c, s, off, nb, nf;
        c = cap_now();
        s = step_now();
        off = m_index * c + m_fill + n;
        if (off > s * c) return 0;
        nb = off / c;
        nf = off % c;
        if (nb == s)
        begin
            nb = s - 1;
            nf = c;
        end
        m_first = (m_first + (nb - m_index) * c) & PMASK;
        m_index = nb;
        m_fill = nf;
        return 1;
    endfunction

    function automatic bit push_run(logic [63:0] start, logic [63:0] len);
        int b, t;
        if (len == 0) return 1;
        if (m_used > 0)
        begin
            b = (m_head + m_used - 1) % PD;
            if (((m_rstart[b] + m_rlen[b]) & PMASK) == start && m_rlen[b] + len <= 64'h1FFFFFF)
            begin
                m_rlen[b] += len;
                return 1;
            end
        end
        if (m_used >= PD) return 0;
        t = (m_head + m_used) % PD;
        m_rstart[t] = start;
        m_rlen[t] = len;
        m_used++;
        return 1;
    endfunction

    function automatic bit pop_run(logic [63:0] n, output logic [63:0] pg);
        int h;
        h = m_head;
        pg = 0;
        if (m_used == 0 || m_rlen[h] < n) return 0;
        pg = m_rstart[h];
        m_rstart[h] = (m_rstart[h] + n) & PMASK;
        m_rlen[h] -= n;
        if (m_rlen[h] == 0)
        begin
            m_head = (h + 1) % PD;
            m_used--;
        end
        return 1;
    endfunction

    function automatic grant_t allocate(op_t op_in, logic [63:0] cnt, logic [63:0] target,
                                        logic [63:0] tail);
        grant_t g;
        op_t op;
        logic [63:0] pg, c, s, rem, p, bid, f;
        status_t st;
        op = op_in;
        pg = 0;
        st = ST_OK;
        c = cap_now();
        s = step_now();
        if (op == OP_APPEND_RUN && cnt == 1) op = OP_APPEND_ONE;
        case (op)
            OP_APPEND_ONE:
                if (!pop_run(1, pg))
                begin
                    if (m_fill >= c) open_block(tail);
                    pg = (m_first + m_fill) & PMASK;
                    m_fill++;
                end
            OP_APPEND_RUN:
                if (cnt == 0) st = ST_ZERO;
                else if (!pop_run(cnt, pg))
                begin
                    if (m_fill >= c) open_block(tail);
                    if (!m_known) st = ST_NO_STEP;
                    else if (cnt > step_room()) st = ST_EXCEEDS;
                    else
                    begin
                        p = (m_first + m_fill) & PMASK;
                        if (advance(cnt)) pg = p;
                        else st = ST_EXCEEDS;
                    end
                end
            OP_RESERVE:
                if (cnt == 0) st = ST_ZERO;
                else
                begin
                    if (m_fill >= c) open_block(tail);
                    if (m_known)
                    begin
                        if (cnt > s * c) st = ST_EXCEEDS;
                        else
                        begin
                            rem = step_room();
                            if (rem < cnt)
                            begin
                                if (!push_run((m_first + m_fill) & PMASK, rem))
                                    st = ST_POOL_FULL;
                                else
                                    open_step(tail);
                            end
                            if (st == ST_OK)
                            begin
                                p = (m_first + m_fill) & PMASK;
                                if (advance(cnt)) pg = p;
                                else st = ST_EXCEEDS;
                            end
                        end
                    end
                    else if (m_fill > c || cnt > c - m_fill) st = ST_NO_STEP;
                    else
                    begin
                        pg = (m_first + m_fill) & PMASK;
                        m_fill += cnt;
                    end
                end
            default:
                if (target > ((m_first + m_fill) & PMASK))
                begin
                    bid = target / c;
                    f = target % c;
                    if (f == 0)
                    begin
                        bid--;
                        f = c;
                    end
                    m_first = (bid * c) & PMASK;
                    m_fill = f;
                    m_index = bid % s;
                    m_known = 1'b1;
                end
        endcase
        g.page = pg[PB-1:0];
        g.st = st;
        g.endp = (m_first + m_fill) & PMASK;
        return g;
    endfunction

    task automatic send_word(op_t op, logic [63:0] cnt, logic [63:0] target, logic [63:0] tail);
        grant_t g;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        run_pages <= cnt[RUN_BITS-1:0];
        target_page <= target[PB-1:0];
        file_tail_page <= tail[PB-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        g = allocate(op, cnt[RUN_BITS-1:0], target[PB-1:0], tail[PB-1:0]);
        grants_due = {grants_due, g};
        @(negedge clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (grants_due.size() > 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CAP_BITS-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BLOCK_CAPACITY) m_cap = val;
        else m_step = val[STEP_BITS-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (grants_due.size() == 0)
            begin
                $display("%0t: unexpected word page=%h status=%0d end=%h", $time,
                         page_number, status, end_page);
                errors++;
            end
            else
            begin
                want = grants_due[0];
                grants_due.delete(0);
                if (page_number !== want.page)
                begin
                    $display("%0t: page_number exp %h got %h", $time, want.page, page_number);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.st, status);
                    errors++;
                end
                if (end_page !== want.endp)
                begin
                    $display("%0t: end_page exp %h got %h", $time, want.endp, end_page);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand_page();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return v & PMASK;
            1: return v & 64'hFFFF;
            2: return ((m_first + m_fill) & PMASK) + $urandom_range(300);
            default: return PMASK - $urandom_range(500);
        endcase
    endfunction

    function automatic logic [63:0] rand_count();
        case ($urandom_range(9))
            0: return $urandom_range(1);
            1: return {$urandom} & 64'h1FFFFFF;
            2: return 64'h1FFFFFF - $urandom_range(3);
            default: return $urandom_range(1, 3 * cap_now());
        endcase
    endfunction

    task automatic test_directed();
        send_word(OP_APPEND_ONE, 0, 0, 0);
        send_word(OP_APPEND_RUN, 1, 0, 0);
        send_word(OP_APPEND_RUN, 0, 0, 0);
        send_word(OP_RESERVE, 0, 0, 0);
        send_word(OP_APPEND_RUN, 20, 0, 0);
        send_word(OP_APPEND_RUN, 64'h1FFFFFF, 0, 0);
        send_word(OP_RESERVE, 65, 0, 0);
        send_word(OP_RESERVE, 30, 0, 500);
        send_word(OP_RESERVE, 40, 0, 0);
        send_word(OP_APPEND_ONE, 0, 0, 0);
        send_word(OP_APPEND_RUN, 5, 0, 0);
        send_word(OP_REPOSITION, 0, 0, 0);
        send_word(OP_REPOSITION, 0, 1024, 0);
        send_word(OP_REPOSITION, 0, 1037, 0);
        send_word(OP_RESERVE, 64, 0, PMASK);
        send_word(OP_REPOSITION, 0, PMASK, 0);
        send_word(OP_APPEND_ONE, 0, 0, 0);
        send_word(OP_RESERVE, 10, 0, 0);
        send_word(OP_APPEND_RUN, 64'h1FFFFFF, PMASK, PMASK);
    endtask

    task automatic test_pool_fill();
        for (int i = 0; i < 40; i++)
            send_word(OP_RESERVE, cap_now() * step_now() - $urandom_range(2), 0,
                      (i % 3 == 0) ? ((m_first + m_fill) & PMASK) + 100000 : 0);
        for (int i = 0; i < 20; i++)
            send_word(OP_APPEND_RUN, $urandom_range(1, 4), 0, 0);
    endtask

    task automatic test_random(int n);
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            op = op_t'($urandom_range(3));
            if (op == OP_REPOSITION && $urandom_range(3) != 0) op = OP_RESERVE;
            send_word(op, rand_count(), rand_page(), $urandom_range(1) ? 0 : rand_page());
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        test_random(60);
    endtask

    task automatic test_configs();
        write_reg(CFG_BLOCK_CAPACITY, 1);
        write_reg(CFG_STEP_SIZE, 1);
        test_random(120);
        write_reg(CFG_BLOCK_CAPACITY, 17'd65536);
        write_reg(CFG_STEP_SIZE, 9'd256);
        test_random(80);
        write_reg(CFG_BLOCK_CAPACITY, 0);
        write_reg(CFG_STEP_SIZE, 0);
        test_random(80);
        write_reg(CFG_BLOCK_CAPACITY, 17'h1FFFF);
        write_reg(CFG_STEP_SIZE, 9'h1FF);
        test_random(60);
        write_reg(CFG_BLOCK_CAPACITY, 7);
        write_reg(CFG_STEP_SIZE, 3);
        test_pool_fill();
        test_random(200);
        write_reg(CFG_STEP_SIZE, 1);
        test_random(100);
        write_reg(CFG_BLOCK_CAPACITY, 3);
        write_reg(CFG_STEP_SIZE, 5);
        test_random(150);
    endtask

    initial
    begin
        m_cap = 16;
        m_step = 4;
        m_first = 0;
        m_fill = 0;
        m_index = 0;
        m_known = 1'b1;
        m_head = 0;
        m_used = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_pool_fill();
        send_idle = 15;
        recv_idle = 66;
        test_random(250);
        send_idle = 66;
        recv_idle = 15;
        test_random(250);
        test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        test_random(360);
        send_idle = 15;
        recv_idle = 30;
        test_configs();
        drain();
        if (errors == 0 && grants_due.size() == 0)
            $display("stepped_page_allocator_core: match");
        else
            $display("stepped_page_allocator_core: mismatch");
        $finish;
    end
endmodule
